@@ sv/qau_pkg.sv @@
// ----------------------------------------------------------------------------
// qau_pkg
// shared types, operation codes and saturation helper for the quaternion unit
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

    localparam int COMP_W   = 32;
    localparam int S_DATA_W = 9 * COMP_W;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 4 * COMP_W;
    localparam int WIDE_W   = 64;

    // component order inside a quaternion: 0 = i, 1 = j, 2 = k, 3 = w
    localparam int IDX_I = 0;
    localparam int IDX_J = 1;
    localparam int IDX_K = 2;
    localparam int IDX_W = 3;

    typedef enum logic [S_USER_W-1:0] {
        FUNC_ADD   = 3'd0,
        FUNC_SUB   = 3'd1,
        FUNC_MUL   = 3'd2,
        FUNC_CONJ  = 3'd3,
        FUNC_SCALE = 3'd4,
        FUNC_ROT   = 3'd5
    } func_t;

    typedef logic [3:0][COMP_W-1:0] quat_t;

    // side data that rides along with the first hamilton pass
    typedef struct packed {
        logic [S_USER_W-1:0] func;
        quat_t               direct;
        quat_t               conj_a;
    } side1_t;

    // side data that rides along with the second hamilton pass
    typedef struct packed {
        logic [S_USER_W-1:0] func;
        quat_t               res1;
    } side2_t;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -64'sd2147483648;
    localparam logic [COMP_W-1:0] MAX_COMP = 32'h7fff_ffff;
    localparam logic [COMP_W-1:0] MIN_COMP = 32'h8000_0000;

    function automatic logic [COMP_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        if (x > SAT_HI)
        begin
            return MAX_COMP;
        end
        else if (x < SAT_LO)
        begin
            return MIN_COMP;
        end
        return x[COMP_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ sv/qau_prep.sv @@
// ----------------------------------------------------------------------------
// qau_prep
// input stage: add, subtract, conjugate and operand select for the product
// ----------------------------------------------------------------------------
`default_nettype none

module qau_prep (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [qau_pkg::S_USER_W-1:0]  in_func,
    input  wire  qau_pkg::quat_t          in_a,
    input  wire  qau_pkg::quat_t          in_b,
    input  wire  [qau_pkg::COMP_W-1:0]    in_scalar,
    output logic                          out_valid,
    input  wire                           out_ready,
    output qau_pkg::quat_t                out_x,
    output qau_pkg::quat_t                out_y,
    output qau_pkg::side1_t               out_side
);
    import qau_pkg::*;

    logic   valid_reg;
    quat_t  x_reg, x_next;
    quat_t  y_reg, y_next;
    side1_t side_reg, side_next;
    logic   en;

    assign en        = !valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_side  = side_reg;

    always_comb
    begin
        logic signed [COMP_W:0] sum_v  [4];
        logic signed [COMP_W:0] diff_v [4];
        logic signed [COMP_W:0] neg_v  [4];

        for (int n = 0; n < 4; n++)
        begin
            sum_v[n]  = $signed({in_a[n][COMP_W-1], in_a[n]})
                      + $signed({in_b[n][COMP_W-1], in_b[n]});
            diff_v[n] = $signed({in_a[n][COMP_W-1], in_a[n]})
                      - $signed({in_b[n][COMP_W-1], in_b[n]});
            neg_v[n]  = -$signed({in_a[n][COMP_W-1], in_a[n]});
        end

        x_next           = in_a;
        side_next.func   = in_func;
        side_next.conj_a = {in_a[IDX_W], sat32(WIDE_W'(neg_v[IDX_K])),
                            sat32(WIDE_W'(neg_v[IDX_J])), sat32(WIDE_W'(neg_v[IDX_I]))};
        side_next.direct = '0;
        y_next           = in_b;

        case (in_func)
            FUNC_ADD:
            begin
                for (int n = 0; n < 4; n++)
                begin
                    side_next.direct[n] = sat32(WIDE_W'(sum_v[n]));
                end
            end
            FUNC_SUB:
            begin
                for (int n = 0; n < 4; n++)
                begin
                    side_next.direct[n] = sat32(WIDE_W'(diff_v[n]));
                end
            end
            FUNC_CONJ:
            begin
                side_next.direct = side_next.conj_a;
            end
            // scale is a product with the pure real quaternion (0,0,0,s)
            FUNC_SCALE:
            begin
                y_next = {in_scalar, {COMP_W{1'b0}}, {COMP_W{1'b0}}, {COMP_W{1'b0}}};
            end
            // rotate treats b as the pure vector (x,y,z,0)
            FUNC_ROT:
            begin
                y_next = {{COMP_W{1'b0}}, in_b[IDX_K], in_b[IDX_J], in_b[IDX_I]};
            end
            default:
            begin
                side_next.direct = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            side_reg <= side_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/qau_hamilton.sv @@
// ----------------------------------------------------------------------------
// qau_hamilton
// three-stage hamilton product x*y with rounding and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module qau_hamilton #(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  wire  qau_pkg::quat_t     in_x,
    input  wire  qau_pkg::quat_t     in_y,
    input  wire  [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    input  wire                      out_ready,
    output qau_pkg::quat_t           out_q,
    output logic [SIDE_W-1:0]        out_side
);
    import qau_pkg::*;

    localparam int TERM_W = WIDE_W - FRAC_BITS;
    localparam int SUM_W  = TERM_W + 2;
    localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(64'sd1 <<< (FRAC_BITS - 1));

    // term m of every component uses x[w], x[i], x[j], x[k] in that order
    localparam logic [1:0] AIDX [4] = '{2'd3, 2'd0, 2'd1, 2'd2};
    localparam logic [1:0] BIDX [4][4] = '{
        '{2'd0, 2'd3, 2'd2, 2'd1},
        '{2'd1, 2'd2, 2'd3, 2'd0},
        '{2'd2, 2'd1, 2'd0, 2'd3},
        '{2'd3, 2'd0, 2'd1, 2'd2}
    };
    // bit m set: term m is subtracted
    localparam logic [3:0] NEG [4] = '{4'b1000, 4'b0010, 4'b0100, 4'b1110};

    logic [2:0] valid_reg;
    logic [2:0] en;

    logic signed [WIDE_W-1:0] prod_reg [4][4];
    logic signed [WIDE_W-1:0] prod_next [4][4];
    logic signed [TERM_W-1:0] term_reg [4][4];
    logic signed [TERM_W-1:0] term_next [4][4];
    quat_t                    q_reg, q_next;
    logic [SIDE_W-1:0]        side1_reg, side2_reg, side3_reg;

    assign en[2]     = !valid_reg[2] || out_ready;
    assign en[1]     = !valid_reg[1] || en[2];
    assign en[0]     = !valid_reg[0] || en[1];
    assign in_ready  = en[0];
    assign out_valid = valid_reg[2];
    assign out_q     = q_reg;
    assign out_side  = side3_reg;

    // stage 1: sixteen 32x32 products
    always_comb
    begin
        logic signed [COMP_W-1:0] xs;
        logic signed [COMP_W-1:0] ys;

        for (int c = 0; c < 4; c++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                xs = $signed(in_x[AIDX[m]]);
                ys = $signed(in_y[BIDX[c][m]]);
                prod_next[c][m] = WIDE_W'(xs) * WIDE_W'(ys);
            end
        end
    end

    // stage 2: round half up and drop the fraction
    always_comb
    begin
        logic signed [WIDE_W-1:0] rnd;

        for (int c = 0; c < 4; c++)
        begin
            for (int m = 0; m < 4; m++)
            begin
                rnd = prod_reg[c][m] + HALF;
                term_next[c][m] = rnd[WIDE_W-1:FRAC_BITS];
            end
        end
    end

    // stage 3: signed sum of four terms, then saturate
    always_comb
    begin
        logic signed [SUM_W-1:0] acc;

        for (int c = 0; c < 4; c++)
        begin
            acc = '0;
            for (int m = 0; m < 4; m++)
            begin
                if (NEG[c][m])
                begin
                    acc = acc - SUM_W'(term_reg[c][m]);
                end
                else
                begin
                    acc = acc + SUM_W'(term_reg[c][m]);
                end
            end
            q_next[c] = sat32(WIDE_W'(acc));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (en[2])
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg  <= prod_next;
            side1_reg <= in_side;
        end
        if (en[1])
        begin
            term_reg  <= term_next;
            side2_reg <= side1_reg;
        end
        if (en[2])
        begin
            q_reg     <= q_next;
            side3_reg <= side2_reg;
        end
    end

endmodule

`default_nettype wire

@@ sv/quaternion_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit_top
// pipelined quaternion add, subtract, product, conjugate, scale and rotate
// ----------------------------------------------------------------------------
// One operation enters per clock cycle as long as the output side keeps
// m_tready high; a stall on the output only holds the stages that are full,
// so bubbles close up and no beat is lost or repeated. Each beat passes
// through the input stage, two hamilton product units of three stages each
// (multiply, round, sum and saturate) and the output register. Rotation runs
// through both product units as a*(v,0) followed by a multiply with conj(a);
// every other operation uses at most the first unit and rides through the
// second unexchanged. All values are signed fixed point with FRAC_BITS
// fraction bits, products round half up, and every result component
// saturates to 32 bits. Selector codes 6 and 7 return an all-zero result.
// s_tready is low during reset and stays low until run_reg is registered
// high after it.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_arithmetic_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    // input beat
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // a_i, a_j, a_k, a_w, b_i, b_j, b_k, b_w, scalar (32 bits each)
    input  wire  [qau_pkg::S_DATA_W-1:0]  s_tdata,
    // func
    input  wire  [qau_pkg::S_USER_W-1:0]  s_tuser,
    // result beat
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // r_i, r_j, r_k, r_w (32 bits each)
    output logic [qau_pkg::M_DATA_W-1:0]  m_tdata
);
    import qau_pkg::*;

    // input fields
    quat_t               in_a;
    quat_t               in_b;
    logic [COMP_W-1:0]   in_scalar;

    // prep stage to first product unit
    logic                prep_ready;
    logic                prep_valid;
    quat_t               prep_x;
    quat_t               prep_y;
    side1_t              prep_side;

    // first product unit to second
    logic                h1_ready;
    logic                h1_valid;
    quat_t               h1_q;
    side1_t              h1_side;
    side2_t              h1_fwd;

    // second product unit to output register
    logic                h2_ready;
    logic                h2_valid;
    quat_t               h2_q;
    side2_t              h2_side;

    logic                run_reg;
    logic                out_valid_reg;
    quat_t               out_data_reg, out_data_next;
    logic                out_en;

    assign in_a      = s_tdata[4*COMP_W-1:0];
    assign in_b      = s_tdata[8*COMP_W-1:4*COMP_W];
    assign in_scalar = s_tdata[9*COMP_W-1:8*COMP_W];

    // hold off input until the pipeline is out of reset
    assign s_tready  = prep_ready && run_reg;

    qau_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid && run_reg),
        .in_ready  (prep_ready),
        .in_func   (s_tuser),
        .in_a      (in_a),
        .in_b      (in_b),
        .in_scalar (in_scalar),
        .out_valid (prep_valid),
        .out_ready (h1_ready),
        .out_x     (prep_x),
        .out_y     (prep_y),
        .out_side  (prep_side)
    );

    // first pass: a*b, a*(0,0,0,s) or a*(v,0)
    qau_hamilton #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(side1_t))
    ) u_ham_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (h1_ready),
        .in_x      (prep_x),
        .in_y      (prep_y),
        .in_side   (prep_side),
        .out_valid (h1_valid),
        .out_ready (h2_ready),
        .out_q     (h1_q),
        .out_side  (h1_side)
    );

    // pick the finished result for everything but rotate
    always_comb
    begin
        h1_fwd.func = h1_side.func;
        case (h1_side.func)
            FUNC_MUL, FUNC_SCALE:
            begin
                h1_fwd.res1 = h1_q;
            end
            default:
            begin
                h1_fwd.res1 = h1_side.direct;
            end
        endcase
    end

    // second pass: (a*(v,0)) * conj(a), used by rotate only
    qau_hamilton #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    ($bits(side2_t))
    ) u_ham_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h1_valid),
        .in_ready  (h2_ready),
        .in_x      (h1_q),
        .in_y      (h1_side.conj_a),
        .in_side   (h1_fwd),
        .out_valid (h2_valid),
        .out_ready (out_en),
        .out_q     (h2_q),
        .out_side  (h2_side)
    );

    // rotate keeps the vector part and clears w
    always_comb
    begin
        case (h2_side.func)
            FUNC_ROT:
            begin
                out_data_next = {{COMP_W{1'b0}}, h2_q[IDX_K], h2_q[IDX_J], h2_q[IDX_I]};
            end
            default:
            begin
                out_data_next = h2_side.res1;
            end
        endcase
    end

    assign out_en   = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg <= 1'b1;
            if (out_en)
            begin
                out_valid_reg <= h2_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/qau_checker.sv @@
// ----------------------------------------------------------------------------
// qau_checker
// port-level checks on the quaternion unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module qau_checker (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    input  wire                           s_tready,
    input  wire  [qau_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire  [qau_pkg::S_USER_W-1:0]  s_tuser,
    input  wire                           m_tvalid,
    input  wire                           m_tready,
    input  wire  [qau_pkg::M_DATA_W-1:0]  m_tdata
);
    import qau_pkg::*;

    // beats from input to output when the output never stalls
    localparam int LAT = 8;

    logic [LAT-1:0] acc_sr_reg, acc_sr_next;
    logic [LAT-1:0] rot_sr_reg, rot_sr_next;
    logic [LAT-1:0] nop_sr_reg, nop_sr_next;
    logic [LAT-2:0] rdy_sr_reg, rdy_sr_next;
    logic           s_beat;
    logic           all_rdy;
    logic [COMP_W-1:0] w_part;

    assign s_beat  = s_tvalid && s_tready;
    assign all_rdy = &rdy_sr_reg;
    assign w_part  = m_tdata[M_DATA_W-1:M_DATA_W-COMP_W];

    assign acc_sr_next = {acc_sr_reg[LAT-2:0], s_beat};
    assign rot_sr_next = {rot_sr_reg[LAT-2:0], s_beat && (s_tuser == FUNC_ROT)};
    assign nop_sr_next = {nop_sr_reg[LAT-2:0], s_beat && (s_tuser > FUNC_ROT)};
    assign rdy_sr_next = {rdy_sr_reg[LAT-3:0], m_tready};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sr_reg <= '0;
            rot_sr_reg <= '0;
            nop_sr_reg <= '0;
            rdy_sr_reg <= '0;
        end
        else
        begin
            acc_sr_reg <= acc_sr_next;
            rot_sr_reg <= rot_sr_next;
            nop_sr_reg <= nop_sr_next;
            rdy_sr_reg <= rdy_sr_next;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        acc_sr_reg[LAT-1] && all_rdy |-> m_tvalid)
        else $error("result missing after pipeline latency");

    a_rot_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rot_sr_reg[LAT-1] && all_rdy |-> m_tvalid && (w_part == '0))
        else $error("rotate result has nonzero w");

    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        nop_sr_reg[LAT-1] && all_rdy |-> m_tvalid && (m_tdata == '0))
        else $error("unused selector gave nonzero result");

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (.*);

`default_nettype wire
